[hdl/dvrt_pkg.sv]
// Shared types and constants for the distance-vector route table.
package dvrt_pkg;
    localparam int ROUTERS_DEF  = 16;
    localparam int COST_INF_DEF = 65535;
    localparam int COST_W       = 16;
    localparam int ID_W         = 4;
    localparam int HOP_W        = 5;
    localparam int TICK_W       = 32;
    localparam logic [HOP_W-1:0] NO_HOP = 5'd16;

    localparam logic [2:0] REQ_EDGE   = 3'd0;
    localparam logic [2:0] REQ_COST   = 3'd1;
    localparam logic [2:0] REQ_TICK   = 3'd2;
    localparam logic [2:0] REQ_ENTRY  = 3'd3;
    localparam logic [2:0] REQ_LOOKUP = 3'd4;

    localparam logic [2:0] OUT_DONE    = 3'd0;
    localparam logic [2:0] OUT_ENTRY   = 3'd1;
    localparam logic [2:0] OUT_FORWARD = 3'd2;
    localparam logic [2:0] OUT_LOCAL   = 3'd3;
    localparam logic [2:0] OUT_DROP    = 3'd4;
    localparam logic [2:0] OUT_UNKNOWN = 3'd5;

    localparam logic [0:0] CFG_LOCAL_ID = 1'd0;
    localparam logic [0:0] CFG_SILENCE  = 1'd1;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic single;    // apply single-item request (edge, cost, entry)
        logic sweep;     // process entry at idx (cost change walk)
        logic emit;      // advertise entry at idx
        logic chk_link;  // check link at nb for silence
        logic fail;      // reroute entry at idx after link fail
        logic tick_inc;
        logic idx_clr;
        logic idx_inc;
        logic nb_clr;
        logic nb_inc;
        logic out_done;  // emit the single result
        logic out_last;
    } dvrt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic idx_end;
        logic nb_end;
        logic present;      // route present at idx
        logic last_present; // route at idx is the highest present one
        logic any_emit;
        logic link_down;    // link at nb just went down
        logic out_busy;
    } dvrt_stat_t;
endpackage

[hdl/distance_vector_route_table.sv]
// Top level of the distance-vector route table.
// Usage:
//  Input channel in_valid/in_ready carries one request item; the result
//  channel out_valid/out_ready returns one or more result items, the final
//  one with out_last set. Configuration is written through cfg_we,
//  cfg_index and cfg_data while the block is idle.
//  Edge, entry and lookup requests are single-step; a cost change walks
//  all ROUTERS entries. A tick advertises entries, then checks
//  each link in turn and, for a link that goes down, walks the table again.
//  One request is in progress at a time; the walks set the rate.
//  Reset clears the tables at once (flip-flop storage) and sets local_id 0,
//  silence_limit 3. A stalled receiver holds the result register and the
//  walk waits; nothing is lost.
module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int ROUTERS  = ROUTERS_DEF,
    parameter int COST_INF = COST_INF_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        req_type,
    input  logic [ID_W-1:0]   node_a,
    input  logic [ID_W-1:0]   node_b,
    input  logic [COST_W-1:0] cost_value,
    input  logic [ID_W-1:0]   dest_id,
    input  logic [HOP_W-1:0]  adv_hop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_kind,
    output logic [ID_W-1:0]   out_dest,
    output logic [HOP_W-1:0]  out_next_hop,
    output logic [COST_W-1:0] out_cost,
    output logic              out_last
);
    dvrt_cmd_t  cmd;
    dvrt_stat_t stat;

    dvrt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .cmd(cmd), .stat(stat)
    );

    dvrt_datapath #(.ROUTERS(ROUTERS), .COST_INF(COST_INF)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .req_type(req_type), .node_a(node_a), .node_b(node_b),
        .cost_value(cost_value), .dest_id(dest_id), .adv_hop(adv_hop),
        .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
        .out_dest(out_dest), .out_next_hop(out_next_hop), .out_cost(out_cost),
        .out_last(out_last)
    );
endmodule

[hdl/dvrt_datapath.sv]
// Datapath: route and link tables, request registers and result register.
module dvrt_datapath
    import dvrt_pkg::*;
#(
    parameter int ROUTERS  = ROUTERS_DEF,
    parameter int COST_INF = COST_INF_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dvrt_cmd_t         cmd,
    output dvrt_stat_t        stat,
    input  logic              cfg_we,
    input  logic              cfg_idx,
    input  logic [7:0]        cfg_data,
    input  logic [2:0]        req_type,
    input  logic [ID_W-1:0]   node_a,
    input  logic [ID_W-1:0]   node_b,
    input  logic [COST_W-1:0] cost_value,
    input  logic [ID_W-1:0]   dest_id,
    input  logic [HOP_W-1:0]  adv_hop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_kind,
    output logic [ID_W-1:0]   out_dest,
    output logic [HOP_W-1:0]  out_next_hop,
    output logic [COST_W-1:0] out_cost,
    output logic              out_last
);
    localparam int IW = (ROUTERS > 16) ? 8 : 4;
    localparam int XW = $clog2(ROUTERS);
    localparam logic [COST_W-1:0] INF = COST_W'(COST_INF);

    logic [COST_W-1:0] r_cost_reg [ROUTERS];
    logic [HOP_W-1:0]  r_hop_reg  [ROUTERS];
    logic [COST_W-1:0] l_cost_reg [ROUTERS];
    logic [TICK_W-1:0] heard_reg  [ROUTERS];
    logic [ROUTERS-1:0] present_reg, nbr_reg, up_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [ID_W-1:0]   local_reg;
    logic [7:0]        silence_reg;

    logic [2:0]        q_type_reg;
    logic [ID_W-1:0]   q_a_reg, q_b_reg, q_d_reg;
    logic [COST_W-1:0] q_cv_reg, q_old_reg;
    logic [HOP_W-1:0]  q_ah_reg;
    logic [IW:0]       idx_reg, nb_reg;
    logic              any_reg;

    logic [XW-1:0] ix, nx;
    assign ix = idx_reg[XW-1:0];
    assign nx = nb_reg[XW-1:0];

    // cost change neighbour resolution
    logic [ID_W-1:0] cc_nb;
    logic [XW-1:0]   cx;
    logic            cc_ok;
    assign cc_nb = (q_a_reg != local_reg) ? q_a_reg : q_b_reg;
    assign cx    = XW'(cc_nb);
    assign cc_ok = (32'(cc_nb) < ROUTERS) && (cc_nb != local_reg) && nbr_reg[cx];

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] x,
                                                   input logic [COST_W-1:0] y);
        logic [COST_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (x >= INF || y >= INF || s >= {1'b0, INF}) return INF;
        return s[COST_W-1:0];
    endfunction

    // per-entry adjust during cost change walk
    logic [COST_W+1:0] adj;
    logic [COST_W-1:0] adj_c;
    always_comb
    begin
        adj = {2'b0, r_cost_reg[ix]} + {2'b0, q_cv_reg} - {2'b0, q_old_reg};
        if (adj[COST_W+1]) adj_c = '0;
        else if (adj[COST_W:0] > {1'b0, INF}) adj_c = INF;
        else adj_c = adj[COST_W-1:0];
    end

    logic [TICK_W-1:0] silent;
    assign silent = tick_reg - heard_reg[nx];

    assign stat.idx_end      = (idx_reg == (IW+1)'(ROUTERS - 1));
    assign stat.nb_end       = (nb_reg == (IW+1)'(ROUTERS - 1));
    assign stat.present      = present_reg[ix];
    assign stat.last_present = ((present_reg >> ix) == ROUTERS'(1));
    assign stat.any_emit     = any_reg;
    assign stat.link_down    = nbr_reg[nx] && up_reg[nx] && (silent > TICK_W'(silence_reg));
    assign stat.out_busy     = out_valid && !out_ready;

    // single-step relax terms
    logic [XW-1:0] sa, sd, sb;
    logic          a_ok, d_ok, b_ok;
    logic          add_a, add_b;
    logic [COST_W-1:0] cand, cv_in;
    assign sa = XW'(q_a_reg);
    assign sb = XW'(q_b_reg);
    assign sd = XW'(q_d_reg);
    assign a_ok = 32'(q_a_reg) < ROUTERS;
    assign b_ok = 32'(q_b_reg) < ROUTERS;
    assign d_ok = 32'(q_d_reg) < ROUTERS;
    assign cand = (q_cv_reg >= INF) ? INF : sat_add(l_cost_reg[sa], q_cv_reg);
    assign cv_in = (cost_value > INF) ? INF : cost_value;

    // edge to a new neighbour, from either end
    assign add_b = (q_a_reg != q_b_reg) && (q_a_reg == local_reg) && b_ok && !nbr_reg[sb];
    assign add_a = (q_a_reg != q_b_reg) && (q_a_reg != local_reg) && (q_b_reg == local_reg)
                   && a_ok && !nbr_reg[sa];

    // single result for non-tick requests
    logic [2:0]        done_kind;
    logic [ID_W-1:0]   done_dest;
    logic [HOP_W-1:0]  done_hop;
    logic [COST_W-1:0] done_cost;
    always_comb
    begin
        done_kind = OUT_DONE;
        done_dest = '0;
        done_hop  = NO_HOP;
        done_cost = '0;
        if (q_type_reg == REQ_ENTRY && !(a_ok && nbr_reg[sa])) begin
            done_kind = OUT_UNKNOWN;
            done_dest = q_d_reg;
        end else if (q_type_reg == REQ_LOOKUP) begin
            done_dest = q_d_reg;
            if (q_d_reg == local_reg) done_kind = OUT_LOCAL;
            else if (!d_ok || !present_reg[sd]) begin
                done_kind = OUT_DROP; done_cost = INF;
            end else if (r_hop_reg[sd] == NO_HOP) begin
                done_kind = OUT_DROP; done_cost = r_cost_reg[sd];
            end else begin
                done_kind = OUT_FORWARD;
                done_hop  = r_hop_reg[sd];
                done_cost = r_cost_reg[sd];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            present_reg <= '0;
            nbr_reg     <= '0;
            up_reg      <= '0;
            tick_reg    <= '0;
            local_reg   <= '0;
            silence_reg <= 8'd3;
            out_valid   <= 1'b0;
            out_kind    <= OUT_DONE;
            out_dest    <= '0;
            out_next_hop <= NO_HOP;
            out_cost    <= '0;
            out_last    <= 1'b0;
            idx_reg     <= '0;
            nb_reg      <= '0;
            any_reg     <= 1'b0;
            q_type_reg  <= REQ_EDGE;
            q_a_reg     <= '0;
            q_b_reg     <= '0;
            q_d_reg     <= '0;
            q_cv_reg    <= '0;
            q_old_reg   <= '0;
            q_ah_reg    <= '0;
            for (int i = 0; i < ROUTERS; i++) begin
                r_cost_reg[i] <= INF;
                r_hop_reg[i]  <= NO_HOP;
                l_cost_reg[i] <= '0;
                heard_reg[i]  <= '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_LOCAL_ID) local_reg <= cfg_data[ID_W-1:0];
                else silence_reg <= cfg_data;
            end
            if (cmd.idx_clr) idx_reg <= '0;
            else if (cmd.idx_inc) idx_reg <= idx_reg + 1'b1;
            if (cmd.nb_clr) nb_reg <= '0;
            else if (cmd.nb_inc) nb_reg <= nb_reg + 1'b1;
            if (cmd.tick_inc) begin
                tick_reg <= tick_reg + 1'b1;
                any_reg  <= 1'b0;
            end

            if (cmd.load) begin
                q_type_reg <= req_type;
                q_a_reg <= node_a;
                q_b_reg <= node_b;
                q_cv_reg <= cv_in;
                q_d_reg <= dest_id;
                q_ah_reg <= adv_hop;
            end

            if (cmd.single) begin
                unique case (q_type_reg)
                    REQ_EDGE:
                    begin
                        if (a_ok) begin
                            present_reg[sa] <= 1'b1;
                            if (add_a) begin
                                nbr_reg[sa] <= 1'b1; up_reg[sa] <= 1'b1;
                                l_cost_reg[sa] <= q_cv_reg; heard_reg[sa] <= '0;
                                r_hop_reg[sa] <= HOP_W'(q_a_reg); r_cost_reg[sa] <= q_cv_reg;
                            end else if (q_a_reg == local_reg) begin
                                r_hop_reg[sa] <= HOP_W'(q_a_reg); r_cost_reg[sa] <= '0;
                            end else if (!present_reg[sa]) begin
                                r_hop_reg[sa] <= NO_HOP; r_cost_reg[sa] <= INF;
                            end
                        end
                        // a self edge is fully handled by the first endpoint
                        if (b_ok && !(a_ok && q_a_reg == q_b_reg)) begin
                            present_reg[sb] <= 1'b1;
                            if (add_b) begin
                                nbr_reg[sb] <= 1'b1; up_reg[sb] <= 1'b1;
                                l_cost_reg[sb] <= q_cv_reg; heard_reg[sb] <= '0;
                                r_hop_reg[sb] <= HOP_W'(q_b_reg); r_cost_reg[sb] <= q_cv_reg;
                            end else if (q_b_reg == local_reg) begin
                                r_hop_reg[sb] <= HOP_W'(q_b_reg); r_cost_reg[sb] <= '0;
                            end else if (!present_reg[sb]) begin
                                r_hop_reg[sb] <= NO_HOP; r_cost_reg[sb] <= INF;
                            end
                        end
                    end
                    REQ_COST:
                    begin
                        // stash old cost, write new
                        if (cc_ok) begin
                            q_old_reg <= l_cost_reg[cx];
                            l_cost_reg[cx] <= q_cv_reg;
                        end
                    end
                    REQ_ENTRY:
                    begin
                        if (a_ok && nbr_reg[sa]) begin
                            up_reg[sa] <= 1'b1;
                            heard_reg[sa] <= tick_reg;
                            if (d_ok && present_reg[sd] && q_d_reg != local_reg) begin
                                if (r_hop_reg[sd] == HOP_W'(q_a_reg)
                                    && q_ah_reg == HOP_W'(local_reg)) begin
                                    r_hop_reg[sd] <= NO_HOP; r_cost_reg[sd] <= INF;
                                end else if (r_hop_reg[sd] == HOP_W'(q_a_reg)
                                             && r_cost_reg[sd] != cand) begin
                                    r_cost_reg[sd] <= cand;
                                    if (cand >= INF) r_hop_reg[sd] <= NO_HOP;
                                end else if (r_hop_reg[sd] != HOP_W'(q_a_reg)
                                             && cand < r_cost_reg[sd]
                                             && q_ah_reg != HOP_W'(local_reg)) begin
                                    r_hop_reg[sd] <= HOP_W'(q_a_reg); r_cost_reg[sd] <= cand;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (cmd.sweep && cc_ok && up_reg[cx] && present_reg[ix]) begin
                if (r_hop_reg[ix] == HOP_W'(cc_nb)) begin
                    if (ix == cx) r_cost_reg[ix] <= q_cv_reg;
                    else if (r_cost_reg[ix] >= INF || q_cv_reg >= INF) r_cost_reg[ix] <= INF;
                    else r_cost_reg[ix] <= adj_c;
                end else if (ix == cx && r_cost_reg[ix] > q_cv_reg) begin
                    r_cost_reg[ix] <= q_cv_reg;
                    r_hop_reg[ix]  <= HOP_W'(cc_nb);
                end
            end

            if (cmd.chk_link && stat.link_down) up_reg[nx] <= 1'b0;

            if (cmd.fail && present_reg[ix] && r_hop_reg[ix] == HOP_W'(nb_reg)) begin
                if (ix != nx && nbr_reg[ix] && up_reg[ix]) begin
                    r_hop_reg[ix] <= HOP_W'(idx_reg); r_cost_reg[ix] <= l_cost_reg[ix];
                end else begin
                    r_hop_reg[ix] <= NO_HOP; r_cost_reg[ix] <= INF;
                end
            end

            if (cmd.emit || cmd.out_done) out_valid <= 1'b1;
            else if (out_valid && out_ready) out_valid <= 1'b0;

            if (cmd.emit) begin
                any_reg   <= 1'b1;
                out_kind  <= OUT_ENTRY;
                out_dest  <= ID_W'(idx_reg);
                out_next_hop <= r_hop_reg[ix];
                out_cost  <= r_cost_reg[ix];
                out_last  <= cmd.out_last;
            end else if (cmd.out_done) begin
                out_last  <= 1'b1;
                out_kind  <= done_kind;
                out_dest  <= done_dest;
                out_next_hop <= done_hop;
                out_cost  <= done_cost;
            end
        end
    end
endmodule

[hdl/dvrt_ctrl.sv]
// Controller: sequences requests, table walks and result hand-off.
module dvrt_ctrl
    import dvrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] req_type,
    output dvrt_cmd_t  cmd,
    input  dvrt_stat_t stat
);
    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_COST, S_EMIT, S_CHECK, S_FAIL, S_DONE
    } state_t;

    state_t state_reg;
    logic [2:0] kind_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE: cmd.load = in_valid;
            S_EXEC:
            begin
                cmd.single  = 1'b1;
                cmd.idx_clr = 1'b1;
                cmd.nb_clr  = 1'b1;
                cmd.tick_inc = (kind_reg == REQ_TICK);
            end
            S_COST:
            begin
                cmd.sweep   = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_EMIT:
            begin
                if (!stat.out_busy) begin
                    // final item when no present entry lies above idx
                    cmd.idx_inc = 1'b1;
                    cmd.emit = stat.present;
                    cmd.out_last = stat.last_present;
                end
            end
            S_CHECK:
            begin
                cmd.chk_link = 1'b1;
                cmd.idx_clr  = 1'b1;
                cmd.nb_inc   = !stat.link_down;
            end
            S_FAIL:
            begin
                cmd.fail = 1'b1;
                cmd.idx_inc = 1'b1;
                cmd.nb_inc = stat.idx_end;
            end
            S_DONE:
            begin
                // a tick with nothing advertised still owes one done item
                cmd.out_done = !stat.out_busy && (kind_reg != REQ_TICK || !stat.any_emit);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            kind_reg  <= REQ_EDGE;
        end else begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid) begin
                        kind_reg  <= req_type;
                        state_reg <= S_EXEC;
                    end
                S_EXEC:
                    if (kind_reg == REQ_COST) state_reg <= S_COST;
                    else if (kind_reg == REQ_TICK) state_reg <= S_EMIT;
                    else state_reg <= S_DONE;
                S_COST:
                    if (stat.idx_end) state_reg <= S_DONE;
                S_EMIT:
                    if (!stat.out_busy && stat.idx_end) state_reg <= S_DONE;
                S_CHECK:
                    if (stat.link_down) state_reg <= S_FAIL;
                    else if (stat.nb_end) state_reg <= S_IDLE;
                    else state_reg <= S_CHECK;
                S_FAIL:
                    if (stat.idx_end) state_reg <= stat.nb_end ? S_IDLE : S_CHECK;
                S_DONE:
                    if (!stat.out_busy) state_reg <= (kind_reg == REQ_TICK) ? S_CHECK : S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[hdl/dvrt_checker.sv]
// Port-level checker for the route table, bound to the top level.
module dvrt_checker
    import dvrt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_last,
    input logic [2:0] out_kind
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_kind <= OUT_UNKNOWN)
        else $error("bad result kind");
    a_last_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> out_kind == OUT_ENTRY)
        else $error("non-final result not a table entry");
endmodule

bind distance_vector_route_table dvrt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_last(out_last),
    .out_kind(out_kind)
);
